FILE: design/aalu_pkg.sv
package aalu_pkg;

  localparam int unsigned DataW = 32;

  // Data-processing opcodes, in instruction encoding order.
  typedef enum logic [3:0] {
    OP_AND = 4'd0,
    OP_EOR = 4'd1,
    OP_SUB = 4'd2,
    OP_RSB = 4'd3,
    OP_ADD = 4'd4,
    OP_ADC = 4'd5,
    OP_SBC = 4'd6,
    OP_RSC = 4'd7,
    OP_TST = 4'd8,
    OP_TEQ = 4'd9,
    OP_CMP = 4'd10,
    OP_CMN = 4'd11,
    OP_ORR = 4'd12,
    OP_MOV = 4'd13,
    OP_BIC = 4'd14,
    OP_MVN = 4'd15
  } alu_op_t;

  // Barrel shifter kinds; ROR with an immediate amount of zero means RRX.
  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_kind_t;

  // Everything needed to build the second operand.
  typedef struct packed {
    logic             use_imm;
    logic [7:0]       imm_byte;
    logic [3:0]       rotate_half;
    shift_kind_t      kind;
    logic             from_reg;
    logic [7:0]       amount;
  } shift_req_t;

  // Flag bit positions inside the status register.
  localparam int unsigned FlagN = 3;
  localparam int unsigned FlagZ = 2;
  localparam int unsigned FlagC = 1;
  localparam int unsigned FlagV = 0;

endpackage

FILE: design/aalu_shifter.sv
module aalu_shifter
  import aalu_pkg::*;
(
  input  shift_req_t       req,
  input  logic [DataW-1:0] reg_value,
  input  logic             carry_in,
  output logic [DataW-1:0] operand,
  output logic             carry_out
);

  logic [2*DataW-1:0] imm_wide;
  logic [DataW-1:0]   imm_rot;
  logic               amt_zero;
  logic [7:0]         eff_amt;
  logic [5:0]         cap_amt;
  logic [2*DataW-1:0] lsl_wide;
  logic [2*DataW-1:0] lsr_wide;
  logic [2*DataW-1:0] asr_wide;
  logic [2*DataW-1:0] ror_wide;
  logic [DataW-1:0]   ror_val;

  // Rotated immediate: rotate right by twice the rotate field.
  assign imm_wide = {24'h0, req.imm_byte, 24'h0, req.imm_byte} >> {req.rotate_half, 1'b0};
  assign imm_rot  = imm_wide[DataW-1:0];

  // An immediate amount of zero encodes a shift by 32 for LSR and ASR.
  assign amt_zero = req.from_reg ? (req.amount == 8'h0) : (req.amount[4:0] == 5'h0);
  assign eff_amt  = req.from_reg ? req.amount :
                    (amt_zero ? 8'd32 : {3'h0, req.amount[4:0]});
  assign cap_amt  = (eff_amt > 8'd32) ? 6'd32 : eff_amt[5:0];

  // Wide shifts keep the last bit shifted out next to the result.
  assign lsl_wide = {32'h0, reg_value} << cap_amt;
  assign lsr_wide = {reg_value, 32'h0} >> cap_amt;
  assign asr_wide = $signed({reg_value, 32'h0}) >>> cap_amt;
  assign ror_wide = {reg_value, reg_value} >> eff_amt[4:0];
  assign ror_val  = ror_wide[DataW-1:0];

  // Operand and shifter carry selection.
  always_comb begin
    operand   = reg_value;
    carry_out = carry_in;
    if (req.use_imm) begin
      operand   = imm_rot;
      carry_out = (req.rotate_half == 4'h0) ? carry_in : imm_rot[DataW-1];
    end else if (amt_zero && (req.from_reg || req.kind == SH_LSL)) begin
      operand   = reg_value;
      carry_out = carry_in;
    end else if (amt_zero && req.kind == SH_ROR) begin
      // Rotate right extended through the carry flag.
      operand   = {carry_in, reg_value[DataW-1:1]};
      carry_out = reg_value[0];
    end else begin
      unique case (req.kind)
        SH_LSL: begin
          operand   = (eff_amt > 8'd32) ? '0 : lsl_wide[DataW-1:0];
          carry_out = (eff_amt > 8'd32) ? 1'b0 : lsl_wide[DataW];
        end
        SH_LSR: begin
          operand   = (eff_amt > 8'd32) ? '0 : lsr_wide[2*DataW-1:DataW];
          carry_out = (eff_amt > 8'd32) ? 1'b0 : lsr_wide[DataW-1];
        end
        SH_ASR: begin
          operand   = asr_wide[2*DataW-1:DataW];
          carry_out = asr_wide[DataW-1];
        end
        SH_ROR: begin
          operand   = ror_val;
          carry_out = ror_val[DataW-1];
        end
        default: begin
          operand   = reg_value;
          carry_out = carry_in;
        end
      endcase
    end
  end

endmodule

FILE: design/arm_data_processing_alu_core.sv
// Channel  | Direction | Handshake            | Word
// in_      | input     | in_valid / in_ready  | opcode, flag request, operands, shift
// out_     | output    | out_valid / out_ready| result, writes_dest, N Z C V
//
// A word passes through the input register and then the result register; out_valid rises
// as the word enters the result register; the shifter and adder sit between the registers.
// One word is accepted every cycle unless the output stalls; the NZCV register is written
// as the word enters the result register, so the next word already sees the updated carry.
// Synchronous active-low reset clears valid bits and the flags to zero.
// A stalled output holds its word; the input register still fills while it waits.
module arm_data_processing_alu_core
  import aalu_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [3:0]       in_alu_op,
  input  logic             in_set_flags,
  input  logic [DataW-1:0] in_first_value,
  input  logic [DataW-1:0] in_reg_value,
  input  logic             in_use_immediate,
  input  logic [7:0]       in_imm_byte,
  input  logic [3:0]       in_rotate_half,
  input  logic [1:0]       in_shift_kind,
  input  logic             in_amount_from_register,
  input  logic [7:0]       in_shift_count,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [DataW-1:0] out_result,
  output logic             out_writes_dest,
  output logic             out_flag_n,
  output logic             out_flag_z,
  output logic             out_flag_c,
  output logic             out_flag_v
);

  logic             in_fire;
  logic             s1_adv;
  logic             s1_valid_r, s1_valid_nxt;
  alu_op_t          op_r;
  logic             set_flags_r;
  logic [DataW-1:0] a_r;
  logic [DataW-1:0] rm_r;
  shift_req_t       req_r;
  logic             out_valid_r, out_valid_nxt;
  logic [DataW-1:0] result_r;
  logic             writes_dest_r;
  logic [3:0]       flags_r, flags_nxt;

  logic [DataW-1:0] b_val;
  logic             sh_carry;
  logic [DataW-1:0] add_x, add_y;
  logic             add_cin;
  logic [DataW:0]   add_sum;
  logic [DataW-1:0] res_val;
  logic             logical;
  logic             is_compare;
  logic             add_v;

  // Handshake: the input register drains whenever the result register is free.
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready     = !s1_valid_r || s1_adv;
  assign in_fire      = in_valid && in_ready;
  assign s1_valid_nxt = in_fire || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && !out_ready);

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r                <= alu_op_t'(in_alu_op);
      set_flags_r         <= in_set_flags;
      a_r                 <= in_first_value;
      rm_r                <= in_reg_value;
      req_r.use_imm       <= in_use_immediate;
      req_r.imm_byte      <= in_imm_byte;
      req_r.rotate_half   <= in_rotate_half;
      req_r.kind          <= shift_kind_t'(in_shift_kind);
      req_r.from_reg      <= in_amount_from_register;
      req_r.amount        <= in_shift_count;
    end
  end

  // Second operand and shifter carry.
  aalu_shifter u_shifter (
    .req       (req_r),
    .reg_value (rm_r),
    .carry_in  (flags_r[FlagC]),
    .operand   (b_val),
    .carry_out (sh_carry)
  );

  // Adder operand selection for the arithmetic opcodes.
  always_comb begin
    add_x   = a_r;
    add_y   = b_val;
    add_cin = 1'b0;
    unique case (op_r)
      OP_SUB, OP_CMP: begin
        add_y   = ~b_val;
        add_cin = 1'b1;
      end
      OP_RSB: begin
        add_x   = b_val;
        add_y   = ~a_r;
        add_cin = 1'b1;
      end
      OP_ADC: begin
        add_cin = flags_r[FlagC];
      end
      OP_SBC: begin
        add_y   = ~b_val;
        add_cin = flags_r[FlagC];
      end
      OP_RSC: begin
        add_x   = b_val;
        add_y   = ~a_r;
        add_cin = flags_r[FlagC];
      end
      default: begin
        add_cin = 1'b0;
      end
    endcase
  end

  assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{DataW{1'b0}}, add_cin};
  assign add_v   = ~(add_x[DataW-1] ^ add_y[DataW-1]) & (add_x[DataW-1] ^ add_sum[DataW-1]);

  // Result selection.
  always_comb begin
    logical = 1'b1;
    res_val = add_sum[DataW-1:0];
    unique case (op_r)
      OP_AND, OP_TST: res_val = a_r & b_val;
      OP_EOR, OP_TEQ: res_val = a_r ^ b_val;
      OP_ORR:         res_val = a_r | b_val;
      OP_MOV:         res_val = b_val;
      OP_BIC:         res_val = a_r & ~b_val;
      OP_MVN:         res_val = ~b_val;
      default: begin
        logical = 1'b0;
        res_val = add_sum[DataW-1:0];
      end
    endcase
  end

  assign is_compare = (op_r == OP_TST) || (op_r == OP_TEQ) ||
                      (op_r == OP_CMP) || (op_r == OP_CMN);

  // Flag update; logical operations take the shifter carry and keep V.
  always_comb begin
    flags_nxt = flags_r;
    if (s1_adv && (set_flags_r || is_compare)) begin
      flags_nxt[FlagN] = res_val[DataW-1];
      flags_nxt[FlagZ] = (res_val == '0);
      flags_nxt[FlagC] = logical ? sh_carry : add_sum[DataW];
      flags_nxt[FlagV] = logical ? flags_r[FlagV] : add_v;
    end
  end

  // Flags and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r     <= 4'h0;
      out_valid_r <= 1'b0;
    end else begin
      flags_r     <= flags_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result_r      <= res_val;
      writes_dest_r <= !is_compare;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result      = result_r;
  assign out_writes_dest = writes_dest_r;
  assign out_flag_n      = flags_r[FlagN];
  assign out_flag_z      = flags_r[FlagZ];
  assign out_flag_c      = flags_r[FlagC];
  assign out_flag_v      = flags_r[FlagV];

endmodule

FILE: design/aalu_checker.sv
module aalu_checker
  import aalu_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [DataW-1:0] out_result,
  input logic             out_flag_c
);

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result) && $stable(out_flag_c))
    else $error("result word changed while stalled");

  // Valid only drops after the word was taken.
  a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(out_ready))
    else $error("result word withdrawn without handshake");

  // The input side only stalls when the output side is blocked.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while output free");

  // After an accepted word, out_valid must be high once the word could have left the input register.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> ##1 out_valid)
    else $error("accepted word did not reach the output");

endmodule

bind arm_data_processing_alu_core aalu_checker u_aalu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_result (out_result),
  .out_flag_c (out_flag_c)
);

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import aalu_pkg::*;

  // One data-processing word as the driver sends it, plus a hold-off mark
  // that makes the driver wait for every outstanding result first.
  typedef struct {
    alu_op_t          op;
    logic             set_flags;
    logic [DataW-1:0] first_value;
    logic [DataW-1:0] reg_value;
    logic             use_imm;
    logic [7:0]       imm_byte;
    logic [3:0]       rotate_half;
    shift_kind_t      kind;
    logic             from_reg;
    logic [7:0]       shift_count;
    bit               hold_off;
  } alu_word_t;

  // One result word as the block should return it.
  typedef struct {
    logic [DataW-1:0] result;
    logic             writes_dest;
    logic             n;
    logic             z;
    logic             c;
    logic             v;
  } alu_result_t;

  localparam int unsigned RandomWords = 880;
  localparam int unsigned CalmTail    = 120;
  localparam int unsigned StallLimit  = 1000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [3:0]       in_alu_op = '0;
  logic             in_set_flags = 1'b0;
  logic [DataW-1:0] in_first_value = '0;
  logic [DataW-1:0] in_reg_value = '0;
  logic             in_use_immediate = 1'b0;
  logic [7:0]       in_imm_byte = '0;
  logic [3:0]       in_rotate_half = '0;
  logic [1:0]       in_shift_kind = '0;
  logic             in_amount_from_register = 1'b0;
  logic [7:0]       in_shift_count = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [DataW-1:0] out_result;
  logic             out_writes_dest;
  logic             out_flag_n;
  logic             out_flag_z;
  logic             out_flag_c;
  logic             out_flag_v;

  alu_word_t   words_to_send[$];
  alu_result_t pending_results[$];
  alu_word_t   word_on_bus;
  logic [3:0]  flags_model = 4'h0;
  bit          in_taken = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned idle_pct = 20;
  int unsigned words_sent = 0;
  int unsigned quiet_cycles = 0;
  int unsigned errors = 0;

  arm_data_processing_alu_core i_dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_alu_op               (in_alu_op),
    .in_set_flags            (in_set_flags),
    .in_first_value          (in_first_value),
    .in_reg_value            (in_reg_value),
    .in_use_immediate        (in_use_immediate),
    .in_imm_byte             (in_imm_byte),
    .in_rotate_half          (in_rotate_half),
    .in_shift_kind           (in_shift_kind),
    .in_amount_from_register (in_amount_from_register),
    .in_shift_count          (in_shift_count),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_result              (out_result),
    .out_writes_dest         (out_writes_dest),
    .out_flag_n              (out_flag_n),
    .out_flag_z              (out_flag_z),
    .out_flag_c              (out_flag_c),
    .out_flag_v              (out_flag_v)
  );

  always #6 clk = ~clk;

  // Barrel shifter: returns {carry out, shifted value}.
  function automatic logic [DataW:0] barrel_shift(input logic [DataW-1:0] val,
                                                   input shift_kind_t kind,
                                                   input logic [7:0] count,
                                                   input logic from_reg,
                                                   input logic cin);
    logic             sign;
    logic [DataW-1:0] fill;
    logic [DataW-1:0] ashifted;
    int               n;
    int               lo;
    sign = val[DataW-1];
    fill = {DataW{sign}};
    lo = int'(count[4:0]);
    n = int'(count);
    if (!from_reg) begin
      // An immediate amount of zero encodes the special forms.
      if (lo == 0) begin
        case (kind)
          SH_LSL:  return {cin, val};
          SH_LSR:  return {sign, {DataW{1'b0}}};
          SH_ASR:  return {sign, fill};
          default: return {val[0], cin, val[DataW-1:1]};
        endcase
      end
      n = lo;
    end else if (n == 0) begin
      return {cin, val};
    end
    ashifted = $signed(val) >>> n;
    case (kind)
      SH_LSL: begin
        if (n < 32) return {val[32-n], val << n};
        return {(n == 32) ? val[0] : 1'b0, {DataW{1'b0}}};
      end
      SH_LSR: begin
        if (n < 32) return {val[n-1], val >> n};
        return {(n == 32) ? sign : 1'b0, {DataW{1'b0}}};
      end
      SH_ASR: begin
        if (n < 32) return {val[n-1], ashifted};
        return {sign, fill};
      end
      default: begin
        if (lo == 0) return {sign, val};
        return {val[lo-1], (val >> lo) | (val << (32 - lo))};
      end
    endcase
  endfunction

  // a + b + cin, returned as {carry, overflow, sum}.
  function automatic logic [DataW+1:0] add_with_carry(input logic [DataW-1:0] a,
                                                       input logic [DataW-1:0] b,
                                                       input logic cin);
    logic [DataW:0] wide;
    logic           ovf;
    wide = {1'b0, a} + {1'b0, b} + {{DataW{1'b0}}, cin};
    ovf = (a[DataW-1] == b[DataW-1]) && (wide[DataW-1] != a[DataW-1]);
    return {wide[DataW], ovf, wide[DataW-1:0]};
  endfunction

  // Works out the result of one word and advances the flag copy.
  function automatic alu_result_t alu_expect(input alu_word_t w);
    logic             cin;
    logic             vin;
    logic             shc;
    logic             logical;
    logic             compare_op;
    logic [DataW:0]   shifted;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    logic [DataW-1:0] r;
    logic             c;
    logic             v;
    int               rot2;
    alu_result_t      res;
    cin = flags_model[FlagC];
    vin = flags_model[FlagV];
    a = w.first_value;
    if (w.use_imm) begin
      rot2 = int'(w.rotate_half) * 2;
      b = ({24'h0, w.imm_byte} >> rot2) | ({24'h0, w.imm_byte} << (32 - rot2));
      shc = (w.rotate_half == 4'h0) ? cin : b[DataW-1];
    end else begin
      shifted = barrel_shift(w.reg_value, w.kind, w.shift_count, w.from_reg, cin);
      b = shifted[DataW-1:0];
      shc = shifted[DataW];
    end
    c = cin;
    v = vin;
    logical = 1'b0;
    case (w.op)
      OP_AND, OP_TST: begin r = a & b; logical = 1'b1; end
      OP_EOR, OP_TEQ: begin r = a ^ b; logical = 1'b1; end
      OP_SUB, OP_CMP: {c, v, r} = add_with_carry(a, ~b, 1'b1);
      OP_RSB:         {c, v, r} = add_with_carry(b, ~a, 1'b1);
      OP_ADD, OP_CMN: {c, v, r} = add_with_carry(a, b, 1'b0);
      OP_ADC:         {c, v, r} = add_with_carry(a, b, cin);
      OP_SBC:         {c, v, r} = add_with_carry(a, ~b, cin);
      OP_RSC:         {c, v, r} = add_with_carry(b, ~a, cin);
      OP_ORR:         begin r = a | b; logical = 1'b1; end
      OP_MOV:         begin r = b; logical = 1'b1; end
      OP_BIC:         begin r = a & ~b; logical = 1'b1; end
      default:        begin r = ~b; logical = 1'b1; end
    endcase
    compare_op = w.op inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN};
    // Logical operations take the shifter carry and keep V.
    if (w.set_flags || compare_op) begin
      if (logical) begin
        c = shc;
        v = vin;
      end
      flags_model = {r[DataW-1], (r == '0), c, v};
    end
    res.result = r;
    res.writes_dest = !compare_op;
    res.n = flags_model[FlagN];
    res.z = flags_model[FlagZ];
    res.c = flags_model[FlagC];
    res.v = flags_model[FlagV];
    return res;
  endfunction

  function automatic alu_word_t make_word(input alu_op_t op, input logic s,
                                          input logic [DataW-1:0] a,
                                          input logic [DataW-1:0] rm,
                                          input logic ui, input logic [7:0] imm,
                                          input logic [3:0] rot, input shift_kind_t kind,
                                          input logic fr, input logic [7:0] cnt);
    alu_word_t w;
    w.op = op;
    w.set_flags = s;
    w.first_value = a;
    w.reg_value = rm;
    w.use_imm = ui;
    w.imm_byte = imm;
    w.rotate_half = rot;
    w.kind = kind;
    w.from_reg = fr;
    w.shift_count = cnt;
    w.hold_off = 1'b0;
    return w;
  endfunction

  // Operands lean toward the corners where carry, overflow and zero flip.
  function automatic logic [DataW-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  function automatic alu_word_t random_word();
    alu_word_t w;
    w.op = alu_op_t'(4'($urandom_range(0, 15)));
    w.set_flags = $urandom_range(0, 3) != 0;
    w.first_value = pick_operand();
    w.reg_value = pick_operand();
    w.use_imm = $urandom_range(0, 2) == 0;
    w.imm_byte = 8'($urandom_range(0, 255));
    w.rotate_half = 4'($urandom_range(0, 15));
    w.kind = shift_kind_t'(2'($urandom_range(0, 3)));
    w.from_reg = 1'($urandom_range(0, 1));
    // Register amounts mostly stay near the 32 boundary.
    if (w.from_reg && $urandom_range(0, 3) != 0) w.shift_count = 8'($urandom_range(0, 40));
    else w.shift_count = 8'($urandom_range(0, 255));
    w.hold_off = 1'b0;
    return w;
  endfunction

  task automatic check_field(input string name, input logic [DataW-1:0] exp_val,
                             input logic [DataW-1:0] act_val);
    if (exp_val !== act_val) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
    end
  endtask

  // Sender: a new word goes out at the falling edge once the last one was taken.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      in_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (words_to_send.size() == 0) begin
        in_valid <= 1'b0;
      end else if (words_to_send[0].hold_off && pending_results.size() != 0) begin
        in_valid <= 1'b0;
      end else if (words_to_send.size() > CalmTail && $urandom_range(0, 99) < idle_pct) begin
        send_gap = $urandom_range(0, 2);
        in_valid <= 1'b0;
      end else begin
        word_on_bus = words_to_send.pop_front();
        in_valid <= 1'b1;
        in_alu_op <= word_on_bus.op;
        in_set_flags <= word_on_bus.set_flags;
        in_first_value <= word_on_bus.first_value;
        in_reg_value <= word_on_bus.reg_value;
        in_use_immediate <= word_on_bus.use_imm;
        in_imm_byte <= word_on_bus.imm_byte;
        in_rotate_half <= word_on_bus.rotate_half;
        in_shift_kind <= word_on_bus.kind;
        in_amount_from_register <= word_on_bus.from_reg;
        in_shift_count <= word_on_bus.shift_count;
      end
    end
  end

  // Receiver: out_ready drops in short random bursts, never in the calm tail.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ready <= 1'b0;
    end else if (words_to_send.size() > CalmTail && $urandom_range(0, 99) < idle_pct) begin
      recv_gap = $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: predicts on each accepted input word and checks each result word.
  always @(posedge clk) begin
    if (rst_n) begin
      quiet_cycles++;
      if (in_valid && in_ready) begin
        pending_results.push_back(alu_expect(word_on_bus));
        in_taken = 1'b1;
        quiet_cycles = 0;
        words_sent++;
        // Switch between busy and stall-free stretches now and then.
        if (words_sent % 150 == 0) begin
          case ($urandom_range(0, 2))
            0:       idle_pct = 0;
            1:       idle_pct = 15;
            default: idle_pct = 40;
          endcase
        end
      end
      if (out_valid && out_ready) begin
        alu_result_t exp_res;
        quiet_cycles = 0;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word, expected none, actual result %h",
                   $time, out_result);
        end else begin
          exp_res = pending_results.pop_front();
          check_field("result", exp_res.result, out_result);
          check_field("writes_dest", 32'(exp_res.writes_dest), 32'(out_writes_dest));
          check_field("flag_n", 32'(exp_res.n), 32'(out_flag_n));
          check_field("flag_z", 32'(exp_res.z), 32'(out_flag_z));
          check_field("flag_c", 32'(exp_res.c), 32'(out_flag_c));
          check_field("flag_v", 32'(exp_res.v), 32'(out_flag_v));
        end
      end
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, StallLimit);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    alu_word_t w;
    // Directed words: every opcode, the operand corners and the shifter
    // special forms.
    words_to_send.push_back(make_word(OP_AND, 1, 32'hFFFF_FFFF, 0, 1, 8'hFF, 0, SH_LSL, 0, 0));
    words_to_send.push_back(make_word(OP_EOR, 1, 0, 0, 1, 8'hFF, 1, SH_LSL, 0, 0));
    words_to_send.push_back(make_word(OP_SUB, 1, 0, 1, 0, 0, 0, SH_LSL, 0, 0));
    words_to_send.push_back(make_word(OP_RSB, 1, 1, 0, 0, 0, 0, SH_LSL, 0, 0));
    words_to_send.push_back(make_word(OP_ADD, 1, 32'h7FFF_FFFF, 0, 1, 8'h01, 0, SH_LSL, 0, 0));
    words_to_send.push_back(make_word(OP_ADC, 1, 32'hFFFF_FFFF, 1, 0, 0, 0, SH_LSL, 0, 0));
    words_to_send.push_back(make_word(OP_SBC, 1, 32'h8000_0000, 1, 0, 0, 0, SH_LSL, 1, 0));
    words_to_send.push_back(make_word(OP_RSC, 1, 32'hFFFF_FFFF, 0, 0, 0, 0, SH_LSL, 0, 0));
    words_to_send.push_back(make_word(OP_TST, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, SH_LSR, 0, 0));
    words_to_send.push_back(make_word(OP_TEQ, 0, 32'hFFFF_FFFF, 32'h8000_0000, 0, 0, 0,
                                      SH_ASR, 0, 0));
    words_to_send.push_back(make_word(OP_CMP, 0, 5, 5, 0, 0, 0, SH_LSL, 0, 0));
    words_to_send.push_back(make_word(OP_CMN, 0, 32'hFFFF_FFFF, 1, 0, 0, 0, SH_LSL, 0, 0));
    words_to_send.push_back(make_word(OP_ORR, 1, 0, 32'h8000_0001, 0, 0, 0, SH_ROR, 0, 0));
    words_to_send.push_back(make_word(OP_MOV, 1, 0, 32'h8000_0001, 0, 0, 0, SH_ROR, 0, 8'hE1));
    words_to_send.push_back(make_word(OP_BIC, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0,
                                      SH_LSL, 1, 32));
    words_to_send.push_back(make_word(OP_MVN, 1, 0, 32'hFFFF_FFFF, 0, 0, 0, SH_LSL, 1, 33));
    words_to_send.push_back(make_word(OP_MOV, 1, 0, 32'h8000_0000, 0, 0, 0, SH_LSR, 1, 32));
    words_to_send.push_back(make_word(OP_MOV, 1, 0, 32'h8000_0000, 0, 0, 0, SH_LSR, 1, 200));
    words_to_send.push_back(make_word(OP_MOV, 1, 0, 32'h8000_0000, 0, 0, 0, SH_ASR, 1, 255));
    words_to_send.push_back(make_word(OP_MOV, 1, 0, 32'h8000_0000, 0, 0, 0, SH_ROR, 1, 32));
    words_to_send.push_back(make_word(OP_MOV, 1, 0, 32'h8000_00F0, 0, 0, 0, SH_ROR, 1, 68));
    words_to_send.push_back(make_word(OP_MOV, 0, 0, 0, 1, 8'hFF, 4'hF, SH_LSL, 0, 0));
    words_to_send.push_back(make_word(OP_ADD, 0, 32'hFFFF_FFFF, 1, 0, 0, 0, SH_LSL, 0, 0));
    words_to_send.push_back(make_word(OP_MOV, 1, 0, 32'h8000_0000, 0, 0, 0, SH_ASR, 1, 31));
    words_to_send.push_back(make_word(OP_MOV, 1, 0, 32'h7FFF_FFFF, 0, 0, 0, SH_ASR, 0, 5));

    // Random words; a couple wait for the pipeline to drain first.
    for (int i = 0; i < RandomWords; i++) begin
      w = random_word();
      w.hold_off = (i == 0) || (i == RandomWords / 2);
      words_to_send.push_back(w);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for the last word to drain, then a few cycles for stray results.
    while (words_to_send.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
design/aalu_pkg.sv
design/aalu_shifter.sv
design/arm_data_processing_alu_core.sv
design/aalu_checker.sv
verif/testbench.sv
